// ===== rtl/tsjs_pkg.sv =====
`default_nettype none
package tsjs_pkg;

    // table sizes
    localparam int MAX_THREADS = 16;
    localparam int MAX_SEMS    = 8;
    localparam int TIW         = $clog2(MAX_THREADS);
    localparam int SIW         = (MAX_SEMS > 1) ? $clog2(MAX_SEMS) : 1;
    localparam int IDW         = 5;
    localparam int SIDW        = 4;
    localparam int CNTW        = 16;

    // request modes
    localparam logic [3:0] MODE_START   = 4'd0;
    localparam logic [3:0] MODE_CREATE  = 4'd1;
    localparam logic [3:0] MODE_YIELD   = 4'd2;
    localparam logic [3:0] MODE_JOIN    = 4'd3;
    localparam logic [3:0] MODE_JOINALL = 4'd4;
    localparam logic [3:0] MODE_EXIT    = 4'd5;
    localparam logic [3:0] MODE_SEMNEW  = 4'd6;
    localparam logic [3:0] MODE_SIGNAL  = 4'd7;
    localparam logic [3:0] MODE_WAIT    = 4'd8;
    localparam logic [3:0] MODE_DESTROY = 4'd9;

    // thread states
    localparam logic [2:0] TS_FREE  = 3'd0;
    localparam logic [2:0] TS_READY = 3'd1;
    localparam logic [2:0] TS_RUN   = 3'd2;
    localparam logic [2:0] TS_JOIN  = 3'd3;
    localparam logic [2:0] TS_SEM   = 3'd4;
    localparam logic [2:0] TS_DONE  = 3'd5;

    // result codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_REFUSED  = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_EMPTY    = 3'd3;
    localparam logic [2:0] ST_DEADLOCK = 3'd4;

    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_MAKE, OP_SETW, OP_PUSH, OP_DISPATCH, OP_BLOCK,
        OP_SCAN_INIT, OP_SCAN_STEP, OP_EXIT_MARK, OP_SEM_CREATE, OP_SIGNAL,
        OP_WAIT, OP_DESTROY, OP_OUT
    } t_op;

    typedef enum logic [1:0] {AD_CHILD, AD_PAR, AD_HEAD, AD_SCAN} t_rsel;
    typedef enum logic [1:0] {WS_RUN, WS_BEST, WS_PAR} t_wsel;
    typedef enum logic [1:0] {SK_CHILD_RUN, SK_CHILD_PAR, SK_JOIN_ME, SK_SEM} t_skind;

    typedef struct packed {
        t_op        op;
        t_rsel      rsel;
        t_wsel      wsel;
        t_skind     skind;
        logic       set_st;
        logic [2:0] st;
    } t_cmd;

    typedef struct packed {
        logic [3:0] mode;
        logic       run_zero;
        logic       thr_full;
        logic       sem_full;
        logic       rdy_empty;
        logic       init_neg;
        logic       sem_ok;
        logic       join_bad;
        logic       child_done;
        logic       old_neg;
        logic       wait_neg;
        logic       scan_done;
        logic       found;
        logic       best_nz;
        logic       par_join;
        logic       out_free;
    } t_stat;

endpackage
`default_nettype wire

// ===== rtl/tsjs_ctrl.sv =====
`default_nettype none
module tsjs_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire tsjs_pkg::t_stat i_stat,
    output tsjs_pkg::t_cmd     o_cmd
);
    import tsjs_pkg::*;

    typedef enum logic [14:0] {
        S_IDLE      = 15'h0001,
        S_DECODE    = 15'h0002,
        S_MAKE      = 15'h0004,
        S_YIELD     = 15'h0008,
        S_PUSH      = 15'h0010,
        S_PUSH_PAR  = 15'h0020,
        S_DISPATCH  = 15'h0040,
        S_BLOCK     = 15'h0080,
        S_SCAN_INIT = 15'h0100,
        S_SCAN      = 15'h0200,
        S_SCAN_END  = 15'h0400,
        S_EXIT_MARK = 15'h0800,
        S_EXIT_PAR  = 15'h1000,
        S_EXIT_END  = 15'h2000,
        S_OUT       = 15'h4000
    } t_state;

    t_state r_state, n_state;
    logic   r_phase, n_phase;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
        end
    end

    assign o_stall = (r_state != S_IDLE);

    // sequencing of datapath commands
    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        o_cmd   = '{op: OP_NONE, rsel: AD_CHILD, wsel: WS_RUN, skind: SK_SEM,
                    set_st: 1'b0, st: ST_OK};
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_OUT;
                unique case (i_stat.mode)
                    MODE_START, MODE_CREATE: begin
                        if (i_stat.mode == MODE_START && !i_stat.run_zero) begin
                            o_cmd.set_st = 1'b1;
                            o_cmd.st     = ST_REFUSED;
                        end else if (i_stat.thr_full) begin
                            o_cmd.set_st = 1'b1;
                            o_cmd.st     = ST_FULL;
                        end else begin
                            n_state = S_MAKE;
                        end
                    end
                    MODE_YIELD: begin
                        if (i_stat.run_zero) begin
                            o_cmd.set_st = 1'b1;
                            o_cmd.st     = ST_REFUSED;
                        end else if (!i_stat.rdy_empty) begin
                            n_state = S_YIELD;
                        end
                    end
                    MODE_JOIN: begin
                        if (i_stat.join_bad) begin
                            o_cmd.set_st = 1'b1;
                            o_cmd.st     = ST_REFUSED;
                        end else if (i_stat.child_done) begin
                            n_state = S_OUT;
                        end else if (i_stat.rdy_empty) begin
                            o_cmd.set_st = 1'b1;
                            o_cmd.st     = ST_DEADLOCK;
                        end else begin
                            n_state = S_BLOCK;
                        end
                    end
                    MODE_JOINALL, MODE_EXIT: begin
                        if (i_stat.run_zero) begin
                            o_cmd.set_st = 1'b1;
                            o_cmd.st     = ST_REFUSED;
                        end else if (i_stat.mode == MODE_EXIT) begin
                            n_state = S_EXIT_MARK;
                        end else begin
                            n_state = S_SCAN_INIT;
                        end
                    end
                    MODE_SEMNEW: begin
                        if (i_stat.init_neg) begin
                            o_cmd.set_st = 1'b1;
                            o_cmd.st     = ST_REFUSED;
                        end else if (i_stat.sem_full) begin
                            o_cmd.set_st = 1'b1;
                            o_cmd.st     = ST_FULL;
                        end else begin
                            o_cmd.op = OP_SEM_CREATE;
                        end
                    end
                    MODE_SIGNAL: begin
                        if (!i_stat.sem_ok) begin
                            o_cmd.set_st = 1'b1;
                            o_cmd.st     = ST_REFUSED;
                        end else begin
                            o_cmd.op = OP_SIGNAL;
                            if (i_stat.old_neg) n_state = S_SCAN_INIT;
                        end
                    end
                    MODE_WAIT: begin
                        if (i_stat.run_zero || !i_stat.sem_ok) begin
                            o_cmd.set_st = 1'b1;
                            o_cmd.st     = ST_REFUSED;
                        end else if (i_stat.wait_neg && i_stat.rdy_empty) begin
                            o_cmd.set_st = 1'b1;
                            o_cmd.st     = ST_DEADLOCK;
                        end else begin
                            o_cmd.op = OP_WAIT;
                            if (i_stat.wait_neg) n_state = S_BLOCK;
                        end
                    end
                    MODE_DESTROY: begin
                        if (!i_stat.sem_ok) begin
                            o_cmd.set_st = 1'b1;
                            o_cmd.st     = ST_REFUSED;
                        end else begin
                            n_state = S_SCAN_INIT;
                        end
                    end
                    default: begin
                        o_cmd.set_st = 1'b1;
                        o_cmd.st     = ST_REFUSED;
                    end
                endcase
            end
            S_MAKE: begin
                o_cmd.op = OP_MAKE;
                n_state  = S_PUSH;
            end
            S_YIELD: begin
                o_cmd.op   = OP_SETW;
                o_cmd.wsel = WS_RUN;
                n_state    = S_PUSH;
            end
            S_PUSH: begin
                o_cmd.op = OP_PUSH;
                if (i_stat.mode == MODE_START || i_stat.mode == MODE_YIELD) begin
                    n_state = S_DISPATCH;
                end else if (i_stat.mode == MODE_EXIT) begin
                    n_state = S_EXIT_PAR;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_PUSH_PAR: begin
                o_cmd.op = OP_PUSH;
                n_state  = S_EXIT_END;
            end
            S_DISPATCH: begin
                o_cmd.op   = OP_DISPATCH;
                o_cmd.rsel = AD_HEAD;
                n_state    = S_OUT;
            end
            S_BLOCK: begin
                o_cmd.op = OP_BLOCK;
                n_state  = S_DISPATCH;
            end
            S_SCAN_INIT: begin
                o_cmd.op = OP_SCAN_INIT;
                if (i_stat.mode == MODE_JOINALL) begin
                    o_cmd.skind = SK_CHILD_RUN;
                end else if (i_stat.mode == MODE_EXIT) begin
                    o_cmd.skind = r_phase ? SK_CHILD_PAR : SK_JOIN_ME;
                end else begin
                    o_cmd.skind = SK_SEM;
                end
                n_state = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.rsel = AD_SCAN;
                if (i_stat.scan_done) begin
                    n_state = S_SCAN_END;
                end else begin
                    o_cmd.op = OP_SCAN_STEP;
                end
            end
            S_SCAN_END: begin
                n_state = S_OUT;
                if (i_stat.mode == MODE_JOINALL) begin
                    if (i_stat.found && i_stat.rdy_empty) begin
                        o_cmd.set_st = 1'b1;
                        o_cmd.st     = ST_DEADLOCK;
                    end else if (i_stat.found) begin
                        n_state = S_BLOCK;
                    end
                end else if (i_stat.mode == MODE_EXIT && !r_phase) begin
                    o_cmd.op   = OP_SETW;
                    o_cmd.wsel = WS_BEST;
                    n_state    = i_stat.best_nz ? S_PUSH : S_EXIT_PAR;
                end else if (i_stat.mode == MODE_EXIT) begin
                    o_cmd.op   = OP_SETW;
                    o_cmd.wsel = WS_PAR;
                    n_state    = i_stat.found ? S_EXIT_END : S_PUSH_PAR;
                end else if (i_stat.mode == MODE_SIGNAL) begin
                    o_cmd.op   = OP_SETW;
                    o_cmd.wsel = WS_BEST;
                    if (i_stat.best_nz) n_state = S_PUSH;
                end else begin
                    if (i_stat.best_nz) begin
                        o_cmd.set_st = 1'b1;
                        o_cmd.st     = ST_REFUSED;
                    end else begin
                        o_cmd.op = OP_DESTROY;
                    end
                end
            end
            S_EXIT_MARK: begin
                o_cmd.op = OP_EXIT_MARK;
                n_phase  = 1'b0;
                n_state  = S_SCAN_INIT;
            end
            S_EXIT_PAR: begin
                o_cmd.rsel = AD_PAR;
                if (i_stat.par_join) begin
                    n_phase = 1'b1;
                    n_state = S_SCAN_INIT;
                end else begin
                    n_state = S_EXIT_END;
                end
            end
            S_EXIT_END: begin
                if (i_stat.rdy_empty) begin
                    o_cmd.set_st = 1'b1;
                    o_cmd.st     = ST_EMPTY;
                end
                n_state = S_DISPATCH;
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.op = OP_OUT;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

`ifndef NO_ASSERTIONS
    a_accept_decodes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (r_state == S_DECODE))
        else $error("accepted transaction not decoded");
    a_out_then_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == OP_OUT) |=> !o_stall)
        else $error("result issued but input still stalled");
    a_scan_follows_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN_INIT) |=> (r_state == S_SCAN))
        else $error("scan not started after init");
`endif

endmodule
`default_nettype wire

// ===== rtl/tsjs_dp.sv =====
`default_nettype none
module tsjs_dp (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire tsjs_pkg::t_cmd                i_cmd,
    output tsjs_pkg::t_stat                    o_stat,
    input  wire logic [3:0]                    i_mode,
    input  wire logic [tsjs_pkg::IDW-1:0]      i_child_id,
    input  wire logic [tsjs_pkg::SIDW-1:0]     i_sem_id,
    input  wire logic signed [tsjs_pkg::CNTW-1:0] i_init_value,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [2:0]                         o_status,
    output logic [tsjs_pkg::IDW-1:0]           o_running_thread,
    output logic [tsjs_pkg::IDW-1:0]           o_new_id
);
    import tsjs_pkg::*;

    function automatic logic [TIW-1:0] tix(input logic [IDW-1:0] id);
        logic [IDW-1:0] m;
        m = id - 1'b1;
        return m[TIW-1:0];
    endfunction

    // thread and semaphore tables
    logic [IDW-1:0]  r_ring   [MAX_THREADS];
    logic [IDW-1:0]  r_tpar   [MAX_THREADS];
    logic [2:0]      r_tstat  [MAX_THREADS];
    logic [IDW-1:0]  r_twait  [MAX_THREADS];
    logic [CNTW-1:0] r_torder [MAX_THREADS];
    logic signed [CNTW-1:0] r_scnt [MAX_SEMS];
    logic [MAX_SEMS-1:0] r_live;

    // scheduler state
    logic [TIW-1:0]  r_head, r_tail;
    logic [IDW-1:0]  r_cnt, r_run, r_rpar, r_made;
    logic [SIDW-1:0] r_smade;
    logic [CNTW-1:0] r_stamp;

    // transaction registers
    logic [3:0]      r_mode;
    logic [IDW-1:0]  r_child, r_w, r_nid, r_idx, r_best, r_skey;
    logic [SIDW-1:0] r_sid;
    logic signed [CNTW-1:0] r_init;
    logic [2:0]      r_st;
    t_skind          r_skind;
    logic            r_found;
    logic [CNTW-1:0] r_best_age;
    logic            r_ovalid;

    // shared read port of the thread table
    logic [TIW-1:0]  raddr;
    logic [IDW-1:0]  head_id;
    logic [2:0]      rd_status;
    logic [IDW-1:0]  rd_parent, rd_wait;
    logic [CNTW-1:0] rd_order, age;
    logic [SIW-1:0]  sidx;
    logic signed [CNTW-1:0] old_cnt, nv;
    logic            out_free, head_ok, w_ok, blk_sem;
    logic [IDW-1:0]  blk_key, nid_t;
    logic [SIDW-1:0] nid_s;
    logic [2:0]      skind_ts;

    assign head_id = r_ring[r_head];

    always_comb begin
        case (i_cmd.rsel)
            AD_CHILD: raddr = tix(r_child);
            AD_PAR:   raddr = tix(r_rpar);
            AD_HEAD:  raddr = tix(head_id);
            default:  raddr = r_idx[TIW-1:0];
        endcase
    end

    assign rd_status = r_tstat[raddr];
    assign rd_parent = r_tpar[raddr];
    assign rd_wait   = r_twait[raddr];
    assign rd_order  = r_torder[raddr];
    assign age       = r_stamp - rd_order;

    // semaphore entry and count arithmetic
    always_comb begin
        logic [SIDW-1:0] s1;
        s1      = r_sid - 1'b1;
        sidx    = s1[SIW-1:0];
        old_cnt = r_scnt[sidx];
        nv      = (old_cnt != {1'b1, {(CNTW-1){1'b0}}}) ? old_cnt - 16'sd1 : old_cnt;
    end

    assign out_free = !r_ovalid || !i_stall;
    assign head_ok  = (head_id != '0) && (head_id <= IDW'(MAX_THREADS));
    assign w_ok     = (r_w != '0) && (r_w <= IDW'(MAX_THREADS)) &&
                      (r_cnt < IDW'(MAX_THREADS));
    assign blk_sem  = (r_mode == MODE_WAIT);
    assign blk_key  = (r_mode == MODE_JOIN) ? r_child :
                      blk_sem ? {1'b0, r_sid} : '0;
    assign nid_t    = r_made + 1'b1;
    assign nid_s    = r_smade + 1'b1;
    assign skind_ts = (r_skind == SK_JOIN_ME) ? TS_JOIN : TS_SEM;

    // status towards the controller
    always_comb begin
        o_stat.mode       = r_mode;
        o_stat.run_zero   = (r_run == '0);
        o_stat.thr_full   = (r_made >= IDW'(MAX_THREADS));
        o_stat.sem_full   = (r_smade >= SIDW'(MAX_SEMS));
        o_stat.rdy_empty  = (r_cnt == '0);
        o_stat.init_neg   = r_init[CNTW-1];
        o_stat.sem_ok     = (r_sid != '0) && (r_sid <= SIDW'(MAX_SEMS)) && r_live[sidx];
        o_stat.join_bad   = (r_run == '0) || (r_child == '0) || (r_child > r_made) ||
                            (r_child > IDW'(MAX_THREADS)) || (rd_parent != r_run);
        o_stat.child_done = (rd_status == TS_DONE);
        o_stat.old_neg    = old_cnt[CNTW-1];
        o_stat.wait_neg   = nv[CNTW-1];
        o_stat.scan_done  = (r_idx >= r_made);
        o_stat.found      = r_found;
        o_stat.best_nz    = (r_best != '0);
        o_stat.par_join   = (r_rpar != '0) && (r_rpar <= IDW'(MAX_THREADS)) &&
                            (rd_status == TS_JOIN);
        o_stat.out_free   = out_free;
    end

    // control state with reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= '0;
            r_tail   <= '0;
            r_cnt    <= '0;
            r_run    <= '0;
            r_rpar   <= '0;
            r_made   <= '0;
            r_smade  <= '0;
            r_stamp  <= '0;
            r_live   <= '0;
            r_ovalid <= 1'b0;
            for (int i = 0; i < MAX_THREADS; i++) r_tstat[i] <= TS_FREE;
        end else begin
            if (i_cmd.op == OP_OUT) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
            case (i_cmd.op)
                OP_MAKE: r_made <= nid_t;
                OP_PUSH: begin
                    if (w_ok) begin
                        r_tail <= (r_tail == TIW'(MAX_THREADS - 1)) ? '0 : r_tail + 1'b1;
                        r_cnt  <= r_cnt + 1'b1;
                        r_tstat[tix(r_w)] <= TS_READY;
                    end
                end
                OP_DISPATCH: begin
                    if (r_cnt == '0) begin
                        r_run  <= '0;
                        r_rpar <= '0;
                    end else begin
                        r_head <= (r_head == TIW'(MAX_THREADS - 1)) ? '0 : r_head + 1'b1;
                        r_cnt  <= r_cnt - 1'b1;
                        if (head_ok) begin
                            r_run  <= head_id;
                            r_rpar <= rd_parent;
                            r_tstat[raddr] <= TS_RUN;
                        end else begin
                            r_run  <= '0;
                            r_rpar <= '0;
                        end
                    end
                end
                OP_BLOCK: begin
                    if (r_run != '0) r_tstat[tix(r_run)] <= blk_sem ? TS_SEM : TS_JOIN;
                    r_stamp <= r_stamp + 1'b1;
                end
                OP_EXIT_MARK: r_tstat[tix(r_run)] <= TS_DONE;
                OP_SEM_CREATE: begin
                    r_smade <= nid_s;
                    r_live[SIW'(nid_s - 1'b1)] <= 1'b1;
                end
                OP_DESTROY: r_live[sidx] <= 1'b0;
                default: ;
            endcase
        end
    end

    // tables and transaction registers without reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.set_st) r_st <= i_cmd.st;
        case (i_cmd.op)
            OP_LOAD: begin
                r_mode  <= i_mode;
                r_child <= i_child_id;
                r_sid   <= i_sem_id;
                r_init  <= i_init_value;
                r_st    <= ST_OK;
                r_nid   <= '0;
            end
            OP_MAKE: begin
                r_tpar[tix(nid_t)] <= r_run;
                r_w   <= nid_t;
                r_nid <= nid_t;
            end
            OP_SETW: begin
                case (i_cmd.wsel)
                    WS_RUN:  r_w <= r_run;
                    WS_BEST: r_w <= r_best;
                    default: r_w <= r_rpar;
                endcase
            end
            OP_PUSH: if (w_ok) r_ring[r_tail] <= r_w;
            OP_BLOCK: begin
                if (r_run != '0) begin
                    r_twait[tix(r_run)]  <= blk_key;
                    r_torder[tix(r_run)] <= r_stamp;
                end
            end
            OP_SCAN_INIT: begin
                r_idx      <= '0;
                r_found    <= 1'b0;
                r_best     <= '0;
                r_best_age <= '0;
                r_skind    <= i_cmd.skind;
                case (i_cmd.skind)
                    SK_CHILD_RUN, SK_JOIN_ME: r_skey <= r_run;
                    SK_CHILD_PAR:             r_skey <= r_rpar;
                    default:                  r_skey <= {1'b0, r_sid};
                endcase
            end
            OP_SCAN_STEP: begin
                r_idx <= r_idx + 1'b1;
                if (r_skind == SK_CHILD_RUN || r_skind == SK_CHILD_PAR) begin
                    if ((rd_status == TS_READY || rd_status == TS_JOIN ||
                         rd_status == TS_SEM) && rd_parent == r_skey) r_found <= 1'b1;
                end else if (rd_status == skind_ts && rd_wait == r_skey) begin
                    if (r_best == '0 || age > r_best_age) begin
                        r_best     <= r_idx + 1'b1;
                        r_best_age <= age;
                    end
                end
            end
            OP_SEM_CREATE: begin
                r_scnt[SIW'(nid_s - 1'b1)] <= r_init;
                r_nid <= {1'b0, nid_s};
            end
            OP_SIGNAL: begin
                if (old_cnt != {1'b0, {(CNTW-1){1'b1}}}) r_scnt[sidx] <= old_cnt + 16'sd1;
            end
            OP_WAIT: r_scnt[sidx] <= nv;
            OP_OUT: begin
                o_status         <= r_st;
                o_running_thread <= r_run;
                o_new_id         <= r_nid;
            end
            default: ;
        endcase
    end

    assign o_valid = r_ovalid;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt <= IDW'(MAX_THREADS)))
        else $error("ready queue count beyond table");
    a_made_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_made <= IDW'(MAX_THREADS)) && (r_smade <= SIDW'(MAX_SEMS)))
        else $error("creation count beyond table");
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_OUT) |-> out_free)
        else $error("result register overwritten while stalled");
`endif

endmodule
`default_nettype wire

// ===== rtl/thread_scheduler_join_semaphore.sv =====
// channel  | handshake          | payload
// request  | i_valid / o_stall  | i_mode, i_child_id, i_sem_id, i_init_value
// result   | o_valid / i_stall  | o_status, o_running_thread, o_new_id
//
// one request at a time; its run time is set by the scans over the
// thread table, one created thread entry per cycle (exit may scan twice)
// a result waits in an output register; the next request is taken meanwhile
// synchronous active-low reset clears queue, counters and thread states
// o_stall is high while a request is being worked on
`default_nettype none
module thread_scheduler_join_semaphore (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_valid,
    output logic                                  o_stall,
    input  wire logic [3:0]                       i_mode,
    input  wire logic [tsjs_pkg::IDW-1:0]         i_child_id,
    input  wire logic [tsjs_pkg::SIDW-1:0]        i_sem_id,
    input  wire logic signed [tsjs_pkg::CNTW-1:0] i_init_value,
    output logic                                  o_valid,
    input  wire logic                             i_stall,
    output logic [2:0]                            o_status,
    output logic [tsjs_pkg::IDW-1:0]              o_running_thread,
    output logic [tsjs_pkg::IDW-1:0]              o_new_id
);
    import tsjs_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // sequencer
    tsjs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // tables, queue and result register
    tsjs_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_mode           (i_mode),
        .i_child_id       (i_child_id),
        .i_sem_id         (i_sem_id),
        .i_init_value     (i_init_value),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_status         (o_status),
        .o_running_thread (o_running_thread),
        .o_new_id         (o_new_id)
    );

endmodule
`default_nettype wire

// ===== test/thread_scheduler_join_semaphore_tb.sv =====
`default_nettype none
module thread_scheduler_join_semaphore_tb;
    import tsjs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RAND_ITEMS  = 1600;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DIR_ROWS    = 24;

    typedef struct packed {
        logic [2:0] status;
        logic [4:0] running;
        logic [4:0] new_id;
    } sched_res_t;

    typedef struct packed {
        logic [3:0]         mode;
        logic [4:0]         child;
        logic [3:0]         sem;
        logic signed [15:0] init;
        logic               typed;
        sched_res_t         res;
    } sched_row_t;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [3:0]         i_mode;
    logic [4:0]         i_child_id;
    logic [3:0]         i_sem_id;
    logic signed [15:0] i_init_value;
    logic               o_valid;
    logic               i_stall;
    logic [2:0]         o_status;
    logic [4:0]         o_running_thread;
    logic [4:0]         o_new_id;

    thread_scheduler_join_semaphore uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_mode(i_mode), .i_child_id(i_child_id),
        .i_sem_id(i_sem_id), .i_init_value(i_init_value),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_status(o_status), .o_running_thread(o_running_thread),
        .o_new_id(o_new_id)
    );

    // scheduler shadow state
    logic [4:0]  rq_ring [MAX_THREADS];
    logic [3:0]  rq_head, rq_tail;
    logic [4:0]  rq_count;
    logic [4:0]  thr_parent [MAX_THREADS];
    logic [2:0]  thr_state [MAX_THREADS];
    logic [4:0]  thr_key [MAX_THREADS];
    logic [15:0] thr_order [MAX_THREADS];
    logic [15:0] stamp_now;
    logic [4:0]  run_id, run_parent;
    logic [4:0]  thr_made;
    logic [3:0]  sem_made;
    shortint     sem_val [MAX_SEMS];
    logic        sem_alive [MAX_SEMS];

    sched_res_t  sched_results_q [$];
    int          n_errors;
    int          cycles;
    bit          stim_done;

    function automatic bit thr_id_ok(logic [4:0] id);
        return id >= 1 && id <= MAX_THREADS;
    endfunction

    function automatic void rq_push(logic [4:0] id);
        if (!thr_id_ok(id) || rq_count >= MAX_THREADS) return;
        rq_ring[rq_tail] = id;
        rq_tail = rq_tail + 4'd1;
        rq_count = rq_count + 5'd1;
        thr_state[id - 1] = TS_READY;
    endfunction

    function automatic void rq_dispatch();
        logic [4:0] id;
        if (rq_count == 0) begin
            run_id = '0;
            run_parent = '0;
            return;
        end
        id = rq_ring[rq_head];
        rq_head = rq_head + 4'd1;
        rq_count = rq_count - 5'd1;
        run_id = id;
        run_parent = thr_parent[id - 1];
        thr_state[id - 1] = TS_RUN;
    endfunction

    // any child still ready or blocked
    function automatic bit live_child(logic [4:0] p);
        for (int i = 0; i < thr_made; i++)
            if ((thr_state[i] == TS_READY || thr_state[i] == TS_JOIN ||
                 thr_state[i] == TS_SEM) && thr_parent[i] == p)
                return 1;
        return 0;
    endfunction

    // oldest blocked thread by stamp age
    function automatic logic [4:0] oldest_waiter(logic [2:0] kind, logic [4:0] key);
        logic [4:0]  best;
        logic [15:0] best_age, age;
        best = '0;
        best_age = '0;
        for (int i = 0; i < thr_made; i++)
            if (thr_state[i] == kind && thr_key[i] == key) begin
                age = stamp_now - thr_order[i];
                if (best == 0 || age > best_age) begin
                    best = 5'(i + 1);
                    best_age = age;
                end
            end
        return best;
    endfunction

    function automatic void block_current(logic [2:0] kind, logic [4:0] key);
        if (thr_id_ok(run_id)) begin
            thr_state[run_id - 1] = kind;
            thr_key[run_id - 1] = key;
            thr_order[run_id - 1] = stamp_now;
        end
        stamp_now = stamp_now + 16'd1;
        rq_dispatch();
    endfunction

    function automatic bit sem_usable(logic [3:0] s);
        if (s < 1 || s > MAX_SEMS) return 0;
        return sem_alive[s - 1];
    endfunction

    function automatic sched_res_t sched_predict(logic [3:0] mode, logic [4:0] child,
                                                 logic [3:0] sid, logic signed [15:0] init);
        sched_res_t r;
        logic [4:0] me, par, w;
        shortint    v;
        r = '0;
        case (mode)
            MODE_START, MODE_CREATE: begin
                if (mode == MODE_START && run_id != 0) r.status = ST_REFUSED;
                else if (thr_made >= MAX_THREADS) r.status = ST_FULL;
                else begin
                    thr_made = thr_made + 5'd1;
                    r.new_id = thr_made;
                    thr_parent[thr_made - 1] = run_id;
                    rq_push(thr_made);
                    if (mode == MODE_START) rq_dispatch();
                end
            end
            MODE_YIELD: begin
                if (run_id == 0) r.status = ST_REFUSED;
                else if (rq_count != 0) begin
                    rq_push(run_id);
                    rq_dispatch();
                end
            end
            MODE_JOIN: begin
                if (run_id == 0 || child == 0 || child > thr_made || !thr_id_ok(child))
                    r.status = ST_REFUSED;
                else if (thr_parent[child - 1] != run_id) r.status = ST_REFUSED;
                else if (thr_state[child - 1] != TS_DONE) begin
                    if (rq_count == 0) r.status = ST_DEADLOCK;
                    else block_current(TS_JOIN, child);
                end
            end
            MODE_JOINALL: begin
                if (run_id == 0) r.status = ST_REFUSED;
                else if (live_child(run_id)) begin
                    if (rq_count == 0) r.status = ST_DEADLOCK;
                    else block_current(TS_JOIN, 5'd0);
                end
            end
            MODE_EXIT: begin
                me = run_id;
                par = run_parent;
                if (!thr_id_ok(me)) r.status = ST_REFUSED;
                else begin
                    thr_state[me - 1] = TS_DONE;
                    w = oldest_waiter(TS_JOIN, me);
                    if (w != 0) rq_push(w);
                    if (thr_id_ok(par))
                        if (thr_state[par - 1] == TS_JOIN && !live_child(par)) rq_push(par);
                    if (rq_count == 0) r.status = ST_EMPTY;
                    rq_dispatch();
                end
            end
            MODE_SEMNEW: begin
                if (init < 0) r.status = ST_REFUSED;
                else if (sem_made >= MAX_SEMS) r.status = ST_FULL;
                else begin
                    sem_made = sem_made + 4'd1;
                    r.new_id = {1'b0, sem_made};
                    sem_val[sem_made - 1] = init;
                    sem_alive[sem_made - 1] = 1;
                end
            end
            MODE_SIGNAL: begin
                if (!sem_usable(sid)) r.status = ST_REFUSED;
                else begin
                    v = sem_val[sid - 1];
                    if (v < 32767) sem_val[sid - 1] = shortint'(v + 1);
                    if (v < 0) begin
                        w = oldest_waiter(TS_SEM, sid);
                        if (w != 0) rq_push(w);
                    end
                end
            end
            MODE_WAIT: begin
                if (run_id == 0 || !sem_usable(sid)) r.status = ST_REFUSED;
                else begin
                    v = sem_val[sid - 1];
                    if (v > -32768) v = shortint'(v - 1);
                    if (v < 0) begin
                        if (rq_count == 0) r.status = ST_DEADLOCK;
                        else begin
                            sem_val[sid - 1] = v;
                            block_current(TS_SEM, {1'b0, sid});
                        end
                    end else begin
                        sem_val[sid - 1] = v;
                    end
                end
            end
            MODE_DESTROY: begin
                if (!sem_usable(sid)) r.status = ST_REFUSED;
                else if (oldest_waiter(TS_SEM, {1'b0, sid}) != 0) r.status = ST_REFUSED;
                else sem_alive[sid - 1] = 0;
            end
            default: r.status = ST_REFUSED;
        endcase
        r.running = run_id;
        return r;
    endfunction

    // clock
    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    // cycle limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // request side
    initial begin
        sched_row_t  rows [DIR_ROWS];
        sched_row_t  row;
        sched_res_t  exp_res;
        int          gap, pick;
        bit          quiet;

        rows = '{
            '{MODE_YIELD,   5'd0,  4'd0,  16'sd0,      1'b1, '{ST_REFUSED, 5'd0, 5'd0}},
            '{MODE_EXIT,    5'd0,  4'd0,  16'sd0,      1'b1, '{ST_REFUSED, 5'd0, 5'd0}},
            '{MODE_WAIT,    5'd0,  4'd1,  16'sd0,      1'b1, '{ST_REFUSED, 5'd0, 5'd0}},
            '{MODE_SEMNEW,  5'd0,  4'd0,  -16'sd32768, 1'b1, '{ST_REFUSED, 5'd0, 5'd0}},
            '{4'd15,        5'd31, 4'd15, -16'sd1,     1'b1, '{ST_REFUSED, 5'd0, 5'd0}},
            '{MODE_SEMNEW,  5'd0,  4'd0,  16'sd32767,  1'b1, '{ST_OK,      5'd0, 5'd1}},
            '{MODE_SIGNAL,  5'd0,  4'd1,  16'sd0,      1'b1, '{ST_OK,      5'd0, 5'd0}},
            '{MODE_SEMNEW,  5'd0,  4'd0,  16'sd0,      1'b1, '{ST_OK,      5'd0, 5'd2}},
            '{MODE_START,   5'd0,  4'd0,  16'sd0,      1'b1, '{ST_OK,      5'd1, 5'd1}},
            '{MODE_START,   5'd0,  4'd0,  16'sd0,      1'b1, '{ST_REFUSED, 5'd1, 5'd0}},
            '{MODE_CREATE,  5'd0,  4'd0,  16'sd0,      1'b0, '0},
            '{MODE_JOIN,    5'd0,  4'd0,  16'sd0,      1'b1, '{ST_REFUSED, 5'd1, 5'd0}},
            '{MODE_JOIN,    5'd31, 4'd0,  16'sd0,      1'b1, '{ST_REFUSED, 5'd1, 5'd0}},
            '{MODE_WAIT,    5'd0,  4'd2,  16'sd0,      1'b0, '0},
            '{MODE_JOINALL, 5'd0,  4'd0,  16'sd0,      1'b0, '0},
            '{MODE_SIGNAL,  5'd0,  4'd2,  16'sd0,      1'b0, '0},
            '{MODE_DESTROY, 5'd0,  4'd15, 16'sd0,      1'b1, '{ST_REFUSED, 5'd2, 5'd0}},
            '{MODE_CREATE,  5'd0,  4'd0,  16'sd0,      1'b0, '0},
            '{MODE_JOIN,    5'd3,  4'd0,  16'sd0,      1'b0, '0},
            '{MODE_EXIT,    5'd0,  4'd0,  16'sd0,      1'b0, '0},
            '{MODE_YIELD,   5'd0,  4'd0,  16'sd0,      1'b0, '0},
            '{MODE_DESTROY, 5'd0,  4'd1,  16'sd0,      1'b0, '0},
            '{MODE_JOINALL, 5'd0,  4'd0,  16'sd0,      1'b0, '0},
            '{MODE_WAIT,    5'd0,  4'd1,  16'sd0,      1'b0, '0}
        };

        i_rst_n = 0;
        i_valid = 0;
        i_mode = '0;
        i_child_id = '0;
        i_sem_id = '0;
        i_init_value = '0;
        cycles = 0;
        n_errors = 0;
        stim_done = 0;
        quiet = 0;

        // shadow reset
        rq_head = 0; rq_tail = 0; rq_count = 0;
        stamp_now = 0; run_id = 0; run_parent = 0;
        thr_made = 0; sem_made = 0;
        for (int i = 0; i < MAX_THREADS; i++) thr_state[i] = TS_FREE;
        for (int i = 0; i < MAX_SEMS; i++) sem_alive[i] = 0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;

        for (int n = 0; n < DIR_ROWS + RAND_ITEMS; n++) begin
            if (n < DIR_ROWS) begin
                row = rows[n];
            end else begin
                if (n % 200 == 0) quiet = ($urandom_range(0, 3) == 0);
                row = '0;
                pick = $urandom_range(0, 99);
                if (pick < 3)       row.mode = MODE_START;
                else if (pick < 10) row.mode = MODE_CREATE;
                else if (pick < 24) row.mode = MODE_YIELD;
                else if (pick < 34) row.mode = MODE_JOIN;
                else if (pick < 42) row.mode = MODE_JOINALL;
                else if (pick < 54) row.mode = MODE_EXIT;
                else if (pick < 60) row.mode = MODE_SEMNEW;
                else if (pick < 75) row.mode = MODE_SIGNAL;
                else if (pick < 90) row.mode = MODE_WAIT;
                else if (pick < 95) row.mode = MODE_DESTROY;
                else                row.mode = 4'($urandom_range(0, 15));
                // mostly plausible ids, sometimes any bit pattern
                if ($urandom_range(0, 9) == 0) row.child = 5'($urandom_range(0, 31));
                else row.child = 5'($urandom_range(1, thr_made + 1));
                if ($urandom_range(0, 9) == 0) row.sem = 4'($urandom_range(0, 15));
                else row.sem = 4'($urandom_range(1, sem_made + 1));
                case ($urandom_range(0, 9))
                    0:       row.init = 16'($urandom_range(0, 65535));
                    1:       row.init = 16'sd32767;
                    2:       row.init = -16'sd32768;
                    default: row.init = 16'($urandom_range(0, 3));
                endcase
            end

            gap = quiet ? 0 : $urandom_range(0, 13);
            if (gap > 0) begin
                i_valid <= 0;
                repeat (gap) @(posedge i_clk);
            end
            i_valid      <= 1;
            i_mode       <= row.mode;
            i_child_id   <= row.child;
            i_sem_id     <= row.sem;
            i_init_value <= row.init;
            do @(posedge i_clk); while (o_stall);

            // transaction accepted at this edge
            exp_res = sched_predict(row.mode, row.child, row.sem, row.init);
            if (row.typed) exp_res = row.res;
            sched_results_q.push_back(exp_res);
        end
        i_valid <= 0;
        stim_done = 1;

        while (sched_results_q.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (n_errors == 0 && sched_results_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // result side back-pressure
    initial begin
        int hold;
        i_stall = 0;
        @(posedge i_clk);
        forever begin
            hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
            if (hold > 0) begin
                i_stall <= 1;
                repeat (hold) @(posedge i_clk);
            end
            i_stall <= 0;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        sched_res_t want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (sched_results_q.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("unexpected result: status %0d running %0d new_id %0d",
                             o_status, o_running_thread, o_new_id);
            end else begin
                want = sched_results_q.pop_front();
                if (o_status !== want.status || o_running_thread !== want.running ||
                    o_new_id !== want.new_id) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("mismatch: exp %0d/%0d/%0d got %0d/%0d/%0d",
                                 want.status, want.running, want.new_id,
                                 o_status, o_running_thread, o_new_id);
                end
            end
        end
    end

endmodule
`default_nettype wire

// ===== sim.f =====
rtl/tsjs_pkg.sv
rtl/tsjs_ctrl.sv
rtl/tsjs_dp.sv
rtl/thread_scheduler_join_semaphore.sv
test/thread_scheduler_join_semaphore_tb.sv
